// ----- hdl/md5_early_reject_filter_assert.svh -----
// assertion macros for the md5 early reject filter
`ifndef MD5_EARLY_REJECT_FILTER_ASSERT_SVH
`define MD5_EARLY_REJECT_FILTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// clocked check, switched off while reset is high
`define MD5ERF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define MD5ERF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MD5ERF_ASSERT(label, clk, rst, prop, msg)
`define MD5ERF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- hdl/md5erf_pkg.sv -----
// shared types, constants and step tables of the md5 early reject filter
`default_nettype none

package md5erf_pkg;

   localparam int STEPS      = 46;
   localparam int WORD_W     = 32;
   localparam int MSG_WORDS  = 16;
   localparam int MSG_W      = WORD_W * MSG_WORDS;

   // standard md5 initial chaining value
   localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
   localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
   localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
   localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

   // round codes
   localparam int ROUND_F = 0;
   localparam int ROUND_G = 1;
   localparam int ROUND_H = 2;

   typedef struct packed {
      logic [63:0] words_0_1;
      logic [63:0] words_2_3;
      logic [63:0] words_4_5;
      logic [63:0] words_6_7;
      logic [63:0] words_8_9;
      logic [63:0] words_10_11;
      logic [63:0] words_12_13;
      logic [63:0] words_14_15;
      logic [31:0] key_index;
   } req_payload_type;

   typedef struct packed {
      logic        is_match;
      logic [31:0] match_index;
      logic [31:0] d_after_steps;
   } rsp_payload_type;

   // what one cell hands to the next
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      logic [WORD_W-1:0] d;
      logic [MSG_W-1:0]  msg;
      logic [31:0]       key_index;
   } cell_data_type;

   // sine constant of a step
   function automatic logic [WORD_W-1:0] step_const(input int step);
      logic [WORD_W-1:0] k;
      unique case (step)
         0:  k = 32'hd76aa478;  1:  k = 32'he8c7b756;
         2:  k = 32'h242070db;  3:  k = 32'hc1bdceee;
         4:  k = 32'hf57c0faf;  5:  k = 32'h4787c62a;
         6:  k = 32'ha8304613;  7:  k = 32'hfd469501;
         8:  k = 32'h698098d8;  9:  k = 32'h8b44f7af;
         10: k = 32'hffff5bb1;  11: k = 32'h895cd7be;
         12: k = 32'h6b901122;  13: k = 32'hfd987193;
         14: k = 32'ha679438e;  15: k = 32'h49b40821;
         16: k = 32'hf61e2562;  17: k = 32'hc040b340;
         18: k = 32'h265e5a51;  19: k = 32'he9b6c7aa;
         20: k = 32'hd62f105d;  21: k = 32'h02441453;
         22: k = 32'hd8a1e681;  23: k = 32'he7d3fbc8;
         24: k = 32'h21e1cde6;  25: k = 32'hc33707d6;
         26: k = 32'hf4d50d87;  27: k = 32'h455a14ed;
         28: k = 32'ha9e3e905;  29: k = 32'hfcefa3f8;
         30: k = 32'h676f02d9;  31: k = 32'h8d2a4c8a;
         32: k = 32'hfffa3942;  33: k = 32'h8771f681;
         34: k = 32'h6d9d6122;  35: k = 32'hfde5380c;
         36: k = 32'ha4beea44;  37: k = 32'h4bdecfa9;
         38: k = 32'hf6bb4b60;  39: k = 32'hbebfbc70;
         40: k = 32'h289b7ec6;  41: k = 32'heaa127fa;
         42: k = 32'hd4ef3085;  43: k = 32'h04881d05;
         44: k = 32'hd9d4d039;  45: k = 32'he6db99e5;
         default: k = '0;
      endcase
      return k;
   endfunction

   // left rotation amount of a step
   function automatic int rot_amount(input int step);
      int r;
      unique case (((step >> 4) << 2) | (step & 3))
         0:  r = 7;   1:  r = 12;  2:  r = 17;  3:  r = 22;
         4:  r = 5;   5:  r = 9;   6:  r = 14;  7:  r = 20;
         8:  r = 4;   9:  r = 11;  10: r = 16;  11: r = 23;
         default: r = 7;
      endcase
      return r;
   endfunction

   // message word used by a step
   function automatic int msg_index(input int step);
      int w;
      unique case (step >> 4)
         ROUND_F: w = step & 15;
         ROUND_G: w = (5 * step + 1) & 15;
         default: w = (3 * step + 5) & 15;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/md5erf_step_cell.sv -----
// one md5 step as a registered cell of the step chain
`default_nettype none

module md5erf_step_cell #(
   parameter int STEP = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire md5erf_pkg::cell_data_type cell_in,
   output md5erf_pkg::cell_data_type cell_out
);

   localparam int                            ROUND = STEP >> 4;
   localparam int                            W_IDX = md5erf_pkg::msg_index(STEP);
   localparam int                            ROT   = md5erf_pkg::rot_amount(STEP);
   localparam logic [md5erf_pkg::WORD_W-1:0] K     = md5erf_pkg::step_const(STEP);

   logic [md5erf_pkg::WORD_W-1:0] f;
   logic [md5erf_pkg::WORD_W-1:0] m;
   logic [md5erf_pkg::WORD_W-1:0] t;
   logic [md5erf_pkg::WORD_W-1:0] t_rot;
   md5erf_pkg::cell_data_type     cell_in_d;
   md5erf_pkg::cell_data_type     cell_ff;

   // round function
   always_comb begin
      case (ROUND)
         md5erf_pkg::ROUND_F: f = (cell_in.b & cell_in.c) | (~cell_in.b & cell_in.d);
         md5erf_pkg::ROUND_G: f = (cell_in.b & cell_in.d) | (cell_in.c & ~cell_in.d);
         default:             f = cell_in.b ^ cell_in.c ^ cell_in.d;
      endcase
   end

   // step sum and rotation
   assign m     = cell_in.msg[W_IDX*md5erf_pkg::WORD_W +: md5erf_pkg::WORD_W];
   assign t     = cell_in.a + f + m + K;
   assign t_rot = (t << ROT) | (t >> (md5erf_pkg::WORD_W - ROT));

   // rotate the words along, message and index ride with the item
   always_comb begin
      cell_in_d           = cell_in;
      cell_in_d.a         = cell_in.d;
      cell_in_d.d         = cell_in.c;
      cell_in_d.c         = cell_in.b;
      cell_in_d.b         = cell_in.b + t_rot;
   end

   // cell register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff <= cell_in_d;
      end
   end

   assign cell_out = cell_ff;

endmodule

`default_nettype wire

// ----- hdl/md5_early_reject_filter.sv -----
// top level of the md5 early reject filter: 46-cell step chain and compare stage
`default_nettype none

// One item is taken in every clock cycle while busy is low; busy is high only
// during reset. Each item runs through a chain of 46 registered step cells
// (rounds F and G in full, the first 14 steps of round H) and one registered
// compare stage; its result comes out of the compare register in order, as
// a one-cycle pulse on rsp_strobe. The receiver cannot hold results off and
// must take every one in the cycle it is shown. Every item gives a result,
// with is_match set when D after step 46 equals the filter word. Write the
// filter word only while no item is in flight.

`include "md5_early_reject_filter_assert.svh"

module md5_early_reject_filter (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire md5erf_pkg::req_payload_type req_payload,
   output logic                        rsp_strobe,
   output md5erf_pkg::rsp_payload_type rsp_payload,
   input  wire                         csr_write_en,
   input  wire  [31:0]                 csr_write_data
);

   logic                          accept;
   logic [31:0]                   filter_ff;
   md5erf_pkg::cell_data_type     chain [0:md5erf_pkg::STEPS];
   logic                          rsp_strobe_ff;
   md5erf_pkg::rsp_payload_type   rsp_payload_ff;
   md5erf_pkg::rsp_payload_type   rsp_payload_in;

   // input handshake
   assign busy   = reset;
   assign accept = start && !busy;

   // filter word register
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
      end else if (csr_write_en) begin
         filter_ff <= csr_write_data;
      end
   end

   // load the chain head from the item and the initial value
   always_comb begin
      chain[0].valid     = accept;
      chain[0].a         = md5erf_pkg::IV_A;
      chain[0].b         = md5erf_pkg::IV_B;
      chain[0].c         = md5erf_pkg::IV_C;
      chain[0].d         = md5erf_pkg::IV_D;
      chain[0].msg       = {req_payload.words_14_15, req_payload.words_12_13,
                            req_payload.words_10_11, req_payload.words_8_9,
                            req_payload.words_6_7,   req_payload.words_4_5,
                            req_payload.words_2_3,   req_payload.words_0_1};
      chain[0].key_index = req_payload.key_index;
   end

   // step cells
   for (genvar i = 0; i < md5erf_pkg::STEPS; i++) begin : g_step
      md5erf_step_cell #(
         .STEP (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // compare stage, d after step 46 sits in b
   always_comb begin
      rsp_payload_in.is_match      = (chain[md5erf_pkg::STEPS].b == filter_ff);
      rsp_payload_in.match_index   = chain[md5erf_pkg::STEPS].key_index;
      rsp_payload_in.d_after_steps = chain[md5erf_pkg::STEPS].b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff  <= chain[md5erf_pkg::STEPS].valid;
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   // checks
   `MD5ERF_ASSERT(a_latency, clock, reset, accept |-> ##47 rsp_strobe, "item result missing after 47 cycles")
   `MD5ERF_ASSERT(a_no_stray, clock, reset, rsp_strobe |-> $past(accept, 47), "result without an item 47 cycles before")
   `MD5ERF_ASSERT(a_match, clock, reset, rsp_strobe |-> (rsp_payload.is_match == (rsp_payload.d_after_steps == filter_ff)), "match flag disagrees with d and filter word")
   `MD5ERF_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_strobe, "result shown after reset")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// self-checking testbench of the md5 early reject filter
`timescale 1ns / 100ps

module tb_top;

   // expected d words and filter verdicts, in order of acceptance
   class verdict_ledger;
      bit [31:0]                   filter_word;
      md5erf_pkg::rsp_payload_type awaited[$];
      int unsigned                 failures;

      function new();
         filter_word = '0;
         failures    = 0;
      endfunction

      // d after the first 46 md5 steps from the standard initial value
      function bit [31:0] d_after_46_steps(md5erf_pkg::req_payload_type blk);
         bit [31:0] sine [46] = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5};
         int unsigned shifts [12] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23};
         bit [63:0] pairs [8];
         bit [31:0] m [16];
         bit [31:0] a, b, c, d, f, t, rot;
         int        w, s;
         pairs = '{blk.words_0_1, blk.words_2_3, blk.words_4_5, blk.words_6_7,
                   blk.words_8_9, blk.words_10_11, blk.words_12_13, blk.words_14_15};
         for (int k = 0; k < 8; k++) begin
            m[2*k]   = pairs[k][31:0];
            m[2*k+1] = pairs[k][63:32];
         end
         a = 32'h67452301;
         b = 32'hefcdab89;
         c = 32'h98badcfe;
         d = 32'h10325476;
         for (int i = 0; i < 46; i++) begin
            case (i / 16)
               md5erf_pkg::ROUND_F: begin
                  f = (b & c) | (~b & d);
                  w = i;
               end
               md5erf_pkg::ROUND_G: begin
                  f = (b & d) | (c & ~d);
                  w = (5 * i + 1) % 16;
               end
               default: begin
                  f = b ^ c ^ d;
                  w = (3 * i + 5) % 16;
               end
            endcase
            t   = a + f + m[w] + sine[i];
            s   = shifts[(i / 16) * 4 + i % 4];
            rot = (t << s) | (t >> (32 - s));
            // rotate the working words, new b last so it sees the old b
            a = d;
            d = c;
            c = b;
            b = b + rot;
         end
         return b;
      endfunction

      function void set_filter(bit [31:0] word);
         filter_word = word;
      endfunction

      function void note_item(md5erf_pkg::req_payload_type blk);
         md5erf_pkg::rsp_payload_type want;
         want.d_after_steps = d_after_46_steps(blk);
         want.match_index   = blk.key_index;
         want.is_match      = (want.d_after_steps == filter_word);
         awaited.push_back(want);
      endfunction

      function void report(string what, md5erf_pkg::rsp_payload_type want,
                           md5erf_pkg::rsp_payload_type got);
         failures++;
         if (failures <= 10)
            $display("%0t %s: expected match %b index %h d %h, got match %b index %h d %h",
                     $realtime, what, want.is_match, want.match_index, want.d_after_steps,
                     got.is_match, got.match_index, got.d_after_steps);
      endfunction

      function void check_result(md5erf_pkg::rsp_payload_type got);
         md5erf_pkg::rsp_payload_type want;
         if (awaited.size() == 0) begin
            report("result with no item outstanding", '0, got);
            return;
         end
         want = awaited.pop_front();
         if (got.is_match !== want.is_match || got.match_index !== want.match_index ||
             got.d_after_steps !== want.d_after_steps)
            report("result mismatch", want, got);
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // anything still awaited at the end never came out
      function void flag_leftover();
         while (awaited.size() != 0)
            report("result never seen", awaited.pop_front(), '0);
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   md5erf_pkg::req_payload_type req_payload;
   logic                        rsp_strobe;
   md5erf_pkg::rsp_payload_type rsp_payload;
   logic                        csr_write_en;
   logic [31:0]                 csr_write_data;

   verdict_ledger ledger = new();
   int unsigned   idle_pct = 19;

   md5_early_reject_filter u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_strobe     (rsp_strobe),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // every strobed result is checked at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         ledger.check_result(rsp_payload);
   end

   // offer one item, with random idle cycles ahead of it
   task automatic send_block(input md5erf_pkg::req_payload_type blk);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= blk;
      do
         @(posedge clock);
      while (busy !== 1'b0);
      ledger.note_item(blk);
   endtask

   // filter word is only changed with the chain empty
   task automatic write_filter(input bit [31:0] word);
      start <= 1'b0;
      while (ledger.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= word;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      ledger.set_filter(word);
   endtask

   // random block, with all-zero and all-one words mixed in
   function automatic md5erf_pkg::req_payload_type random_block();
      md5erf_pkg::req_payload_type blk;
      bit [31:0]                   wd [16];
      for (int k = 0; k < 16; k++) begin
         case ($urandom_range(9))
            0:       wd[k] = '0;
            1:       wd[k] = '1;
            default: wd[k] = $urandom;
         endcase
      end
      blk.words_0_1   = {wd[1], wd[0]};
      blk.words_2_3   = {wd[3], wd[2]};
      blk.words_4_5   = {wd[5], wd[4]};
      blk.words_6_7   = {wd[7], wd[6]};
      blk.words_8_9   = {wd[9], wd[8]};
      blk.words_10_11 = {wd[11], wd[10]};
      blk.words_12_13 = {wd[13], wd[12]};
      blk.words_14_15 = {wd[15], wd[14]};
      case ($urandom_range(9))
         0:       blk.key_index = '0;
         1:       blk.key_index = '1;
         default: blk.key_index = $urandom;
      endcase
      return blk;
   endfunction

   // stimulus and end of run
   initial begin
      md5erf_pkg::req_payload_type blk;
      md5erf_pkg::req_payload_type empty_msg;
      md5erf_pkg::req_payload_type pool [4];
      bit [31:0]                   filt;

      reset          <= 1'b1;
      start          <= 1'b0;
      req_payload    <= '0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and patterns under the reset filter word
      blk = '0;
      send_block(blk);
      blk = '1;
      send_block(blk);
      blk = {{8{64'haaaa_aaaa_aaaa_aaaa}}, 32'h5555_5555};
      send_block(blk);
      blk = {{8{64'h5555_5555_5555_5555}}, 32'haaaa_aaaa};
      send_block(blk);
      // one field all ones at a time
      for (int k = 0; k < 8; k++) begin
         blk = '0;
         blk[32 + 64 * k +: 64] = '1;
         blk.key_index = k;
         send_block(blk);
      end
      // padded empty message
      empty_msg = '0;
      empty_msg.words_0_1[31:0] = 32'h0000_0080;
      empty_msg.key_index       = 32'h1;
      send_block(empty_msg);
      repeat (4) send_block(random_block());

      // directed: a matching block, a non-matching one, then the matching one again
      write_filter(ledger.d_after_46_steps(empty_msg));
      send_block(empty_msg);
      blk = '0;
      send_block(blk);
      empty_msg.key_index = '1;
      send_block(empty_msg);

      // random phases: both filter extremes, a random word, then match hunting
      for (int p = 0; p < 5; p++) begin
         foreach (pool[k])
            pool[k] = random_block();
         case (p)
            0:       filt = '1;
            1:       filt = '0;
            2:       filt = $urandom;
            default: filt = ledger.d_after_46_steps(pool[$urandom_range(3)]);
         endcase
         write_filter(filt);
         // one phase runs back to back with no idling
         idle_pct = (p == 2) ? 0 : 19;
         repeat (110) begin
            if (p >= 3 && $urandom_range(9) < 3) begin
               blk           = pool[$urandom_range(3)];
               blk.key_index = $urandom;
            end else begin
               blk = random_block();
            end
            send_block(blk);
         end
      end

      // drain, allowing for the full chain latency
      start <= 1'b0;
      for (int n = 0; n < 400 && ledger.pending() != 0; n++)
         @(posedge clock);
      ledger.flag_leftover();
      repeat (60) @(posedge clock);
      if (ledger.failures == 0)
         $display("md5_early_reject_filter regression: pass");
      else
         $display("md5_early_reject_filter regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("md5_early_reject_filter regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/md5erf_pkg.sv
hdl/md5erf_step_cell.sv
hdl/md5_early_reject_filter.sv
dv/tb_top.sv
